// File: rtl/smfr_pkg.sv
// package for the stream map/filter/reduce block
// holds types, codes and fixed-point helpers; no dependencies
package smfr_pkg;

   localparam int MAX_STAGES    = 4;
   localparam int FRACTION_BITS = 32;
   localparam int DATA_W        = 64;
   localparam int KIND_W        = 3;
   localparam int STAGE_IDX_W   = $clog2(MAX_STAGES);
   localparam int COUNT_W       = 3;
   localparam int CSR_IDX_W     = 3;

   typedef logic signed [DATA_W-1:0] data_type;

   // stage kind codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD     = 3'd0,
      KIND_MUL     = 3'd1,
      KIND_GT      = 3'd2,
      KIND_LT      = 3'd3,
      KIND_NONZERO = 3'd4,
      KIND_ZIP     = 3'd5
   } kind_type;

   // terminal mode codes
   localparam logic [1:0] TERM_PASS   = 2'd0;
   localparam logic [1:0] TERM_TOTAL  = 2'd1;
   localparam logic [1:0] TERM_PREFIX = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_KINDS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALAR0     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALAR1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALAR2     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALAR3     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_MODE   = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STAGE,
      ST_MUL,
      ST_TERM,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic                   load;
      logic                   step;
      logic                   mul_start;
      logic                   mul_finish;
      logic                   terminal;
      logic [STAGE_IDX_W-1:0] stage_idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     keep;
      kind_type kind;
   } status_type;

   // saturating signed add
   function automatic data_type sat_add(data_type a, data_type b);
      data_type r;
      r = a + b;
      if ((a[DATA_W-1] == b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1]))
         r = a[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      return r;
   endfunction

endpackage

// File: rtl/smfr_if.sv
// valid/ready channel interface for the stream map/filter/reduce block
// depends on smfr_pkg
interface smfr_req_if;
   logic                  valid;
   logic                  ready;
   smfr_pkg::data_type    element_value;
   smfr_pkg::data_type    zip_value;
   logic                  is_last;
   modport source (output valid, element_value, zip_value, is_last, input ready);
   modport sink   (input valid, element_value, zip_value, is_last, output ready);
endinterface

interface smfr_rsp_if;
   logic                  valid;
   logic                  ready;
   smfr_pkg::data_type    result_value;
   logic                  end_of_stream;
   logic                  no_value;
   modport source (output valid, result_value, end_of_stream, no_value, input ready);
   modport sink   (input valid, result_value, end_of_stream, no_value, output ready);
endinterface

// File: rtl/stream_map_filter_reduce_top.sv
// top level of the stream map/filter/reduce block
// depends on smfr_pkg, smfr_if, smfr_ctrl and smfr_datapath
//
// usage:
//   req channel carries element_value, zip_value and is_last (Q32.32)
//   rsp channel carries result_value, end_of_stream and no_value
//   csr port writes registers 0..6; the user must write them only while idle,
//   the block itself does not enforce it; no read-back
// timing: one word at a time; an item is taken in the idle state, then each
//   stage in use is stepped in a stage state, and one more stage state finishes
//   stepping; each multiply adds a multiply state (the 64x64 product is formed
//   as four 32x32 partials in the stage state and summed in the multiply
//   state); a terminal state and an output state follow
//   a failing filter skips the remaining stages
//   the result word is registered by the terminal step and is
//   held until rsp.ready; items that give no result spend the output cycle
//   with rsp.valid low and then free the block
// reset:
//   synchronous, active high; clears the configuration registers, controller state and the running sum
// stall:
//   a stalled receiver holds the block; req.ready stays low meanwhile
module stream_map_filter_reduce_top (
   input  logic                          clock,
   input  logic                          reset,
   smfr_req_if.sink                      req,
   smfr_rsp_if.source                    rsp,
   input  logic                          csr_write_enable,
   input  logic [smfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [smfr_pkg::DATA_W-1:0]   csr_write_data
);

   logic [smfr_pkg::COUNT_W-1:0] stage_count_ff;
   logic [11:0]                  stage_kinds_ff;
   smfr_pkg::data_type           scalar_ff [smfr_pkg::MAX_STAGES];
   logic [1:0]                   terminal_mode_ff;
   smfr_pkg::cmd_type            cmd;
   smfr_pkg::status_type         status;
   smfr_pkg::status_type         ctrl_status;
   logic                         emit;
   logic                         req_last_q;
   logic                         emit_phase;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_count_ff   <= '0;
         stage_kinds_ff   <= '0;
         terminal_mode_ff <= '0;
         for (int i = 0; i < smfr_pkg::MAX_STAGES; i++) scalar_ff[i] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            smfr_pkg::CSR_STAGE_COUNT: stage_count_ff <= csr_write_data[2:0];
            smfr_pkg::CSR_STAGE_KINDS: stage_kinds_ff <= csr_write_data[11:0];
            smfr_pkg::CSR_SCALAR0:     scalar_ff[0]   <= csr_write_data;
            smfr_pkg::CSR_SCALAR1:     scalar_ff[1]   <= csr_write_data;
            smfr_pkg::CSR_SCALAR2:     scalar_ff[2]   <= csr_write_data;
            smfr_pkg::CSR_SCALAR3:     scalar_ff[3]   <= csr_write_data;
            smfr_pkg::CSR_TERM_MODE:   terminal_mode_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // emit flag: set by the terminal step when a word is due
   always_ff @(posedge clock) begin
      if (reset)           emit <= 1'b0;
      else if (cmd.terminal)
         emit <= (terminal_mode_ff == smfr_pkg::TERM_TOTAL)
                 ? req_last_q : (status.keep | req_last_q);
      else if (cmd.load)   emit <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_last_q <= req.is_last;
   end

   // controller sees filter keep while stepping, emit flag at output
   assign ctrl_status.kind = status.kind;
   assign ctrl_status.keep = cmd.terminal ? 1'b1 : (emit_phase ? emit : status.keep);

   always_ff @(posedge clock) begin
      if (reset)             emit_phase <= 1'b0;
      else if (cmd.terminal) emit_phase <= 1'b1;
      else if (cmd.load)     emit_phase <= 1'b0;
   end

   smfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .stage_count (stage_count_ff),
      .status      (ctrl_status),
      .cmd         (cmd)
   );

   smfr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .element_value (req.element_value),
      .zip_value     (req.zip_value),
      .is_last       (req.is_last),
      .stage_kinds   (stage_kinds_ff),
      .scalar        (scalar_ff),
      .terminal_mode (terminal_mode_ff),
      .result_value  (rsp.result_value),
      .end_of_stream (rsp.end_of_stream),
      .no_value      (rsp.no_value)
   );

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input taken while result pending");
   a_marker_only_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.no_value |-> rsp.end_of_stream && rsp.result_value == '0)
      else $error("end marker carries a value");
   a_load_then_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready) else $error("second item taken at once");

endmodule

// File: rtl/smfr_ctrl.sv
// controller for the stream map/filter/reduce block
// walks the configured stages one at a time; depends on smfr_pkg
module smfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [smfr_pkg::COUNT_W-1:0] stage_count,
   input  smfr_pkg::status_type  status,
   output smfr_pkg::cmd_type     cmd
);

   smfr_pkg::state_type state_ff, state_in;
   logic [smfr_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic [smfr_pkg::COUNT_W-1:0] limit;

   // clamp stage count
   assign limit = (stage_count > smfr_pkg::COUNT_W'(smfr_pkg::MAX_STAGES))
                  ? smfr_pkg::COUNT_W'(smfr_pkg::MAX_STAGES) : stage_count;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smfr_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      cmd.stage_idx  = idx_ff[smfr_pkg::STAGE_IDX_W-1:0];
      unique case (state_ff)
         smfr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = smfr_pkg::ST_STAGE;
            end
         end
         smfr_pkg::ST_STAGE: begin
            if (idx_ff >= limit || !status.keep) begin
               state_in = smfr_pkg::ST_TERM;
            end else if (status.kind == smfr_pkg::KIND_MUL) begin
               cmd.mul_start = 1'b1;
               state_in      = smfr_pkg::ST_MUL;
            end else begin
               cmd.step = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         smfr_pkg::ST_MUL: begin
            cmd.mul_finish = 1'b1;
            idx_in         = idx_ff + 1'b1;
            state_in       = smfr_pkg::ST_STAGE;
         end
         smfr_pkg::ST_TERM: begin
            cmd.terminal = 1'b1;
            state_in     = smfr_pkg::ST_OUT;
         end
         smfr_pkg::ST_OUT: begin
            rsp_valid = status.keep;
            if (!status.keep || rsp_ready)
               state_in = smfr_pkg::ST_IDLE;
         end
         default: state_in = smfr_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: rtl/smfr_datapath.sv
// datapath for the stream map/filter/reduce block
// value register, split multiplier, accumulator and result register; depends on smfr_pkg
module smfr_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  smfr_pkg::cmd_type     cmd,
   output smfr_pkg::status_type  status,
   input  smfr_pkg::data_type    element_value,
   input  smfr_pkg::data_type    zip_value,
   input  logic                  is_last,
   input  logic [11:0]           stage_kinds,
   input  smfr_pkg::data_type    scalar [smfr_pkg::MAX_STAGES],
   input  logic [1:0]            terminal_mode,
   output smfr_pkg::data_type    result_value,
   output logic                  end_of_stream,
   output logic                  no_value
);

   localparam int FB = smfr_pkg::FRACTION_BITS;
   localparam int W  = smfr_pkg::DATA_W;

   smfr_pkg::data_type v_ff, v_in, zip_ff, sum_ff, sum_in;
   logic keep_ff, keep_in, last_ff;
   logic emit_ff, emit_in;
   smfr_pkg::data_type res_ff, res_in;
   logic eos_ff, eos_in, nov_ff, nov_in;
   smfr_pkg::kind_type kind;
   smfr_pkg::data_type s;

   // multiplier partials: magnitudes split into 32-bit halves
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic        neg_ff;
   logic [63:0] ma, mb;
   logic [127:0] prod, sprod;
   logic signed [127:0] shifted;
   smfr_pkg::data_type mul_res;

   assign kind = smfr_pkg::kind_type'(stage_kinds[cmd.stage_idx*3 +: 3]);
   assign s    = scalar[cmd.stage_idx];
   assign ma   = v_ff[W-1] ? 64'(-v_ff) : 64'(v_ff);
   assign mb   = s[W-1] ? 64'(-s) : 64'(s);

   // magnitude product recombined, signed, scaled by the fraction bits and saturated
   always_comb begin
      prod    = {p11_ff, 64'd0} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
                + {64'd0, p00_ff};
      sprod   = neg_ff ? -prod : prod;
      shifted = $signed(sprod) >>> FB;
      if (shifted[127:W-1] == {(129-W){shifted[W-1]}})
         mul_res = shifted[W-1:0];
      else
         mul_res = sprod[127] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   end

   // one stage step, or the end of a multiply
   always_comb begin
      v_in    = v_ff;
      keep_in = keep_ff;
      if (cmd.step) begin
         case (kind)
            smfr_pkg::KIND_ADD:     v_in = smfr_pkg::sat_add(v_ff, s);
            smfr_pkg::KIND_GT:      keep_in = v_ff > s;
            smfr_pkg::KIND_LT:      keep_in = s > v_ff;
            smfr_pkg::KIND_NONZERO: keep_in = v_ff != '0;
            smfr_pkg::KIND_ZIP:     v_in = smfr_pkg::sat_add(v_ff, zip_ff);
            default: ;
         endcase
      end
      if (cmd.mul_finish) v_in = mul_res;
   end

   // terminal
   always_comb begin
      sum_in  = sum_ff;
      emit_in = emit_ff;
      res_in  = res_ff;
      eos_in  = eos_ff;
      nov_in  = nov_ff;
      if (cmd.terminal) begin
         eos_in = last_ff;
         if (terminal_mode == smfr_pkg::TERM_TOTAL) begin
            res_in  = keep_ff ? smfr_pkg::sat_add(sum_ff, v_ff) : sum_ff;
            sum_in  = last_ff ? '0 : res_in;
            emit_in = last_ff;
            nov_in  = 1'b0;
         end else if (keep_ff) begin
            emit_in = 1'b1;
            nov_in  = 1'b0;
            if (terminal_mode == smfr_pkg::TERM_PREFIX) begin
               res_in = smfr_pkg::sat_add(sum_ff, v_ff);
               sum_in = last_ff ? '0 : res_in;
            end else begin
               res_in = v_ff;
               if (last_ff) sum_in = '0;
            end
         end else begin
            emit_in = last_ff;
            res_in  = '0;
            nov_in  = 1'b1;
            if (last_ff) sum_in = '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff    <= element_value;
         zip_ff  <= zip_value;
         last_ff <= is_last;
      end else begin
         v_ff <= v_in;
      end
      if (cmd.mul_start) begin
         p00_ff <= ma[31:0]  * mb[31:0];
         p01_ff <= ma[31:0]  * mb[63:32];
         p10_ff <= ma[63:32] * mb[31:0];
         p11_ff <= ma[63:32] * mb[63:32];
         neg_ff <= v_ff[W-1] ^ s[W-1];
      end
      res_ff <= res_in;
      eos_ff <= eos_in;
      nov_ff <= nov_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         keep_ff <= 1'b1;
         emit_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         keep_ff <= cmd.load ? 1'b1 : keep_in;
         emit_ff <= cmd.load ? 1'b0 : emit_in;
      end
   end

   // status: keep during stages, emit or keep once terminal is done
   assign status.keep = cmd.terminal ? keep_ff : (emit_ff | keep_ff) & (emit_ff | !cmd.terminal)
                        & (emit_ff | keep_ff);
   assign status.kind = kind;
   assign result_value  = res_ff;
   assign end_of_stream = eos_ff;
   assign no_value      = nov_ff;

endmodule
